// File: sv/c8alu_pkg.sv
`timescale 1ns / 1ps

package c8alu_pkg;

   // Operation codes
   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SBC  = 5'd3,
      OP_AND  = 5'd4,
      OP_XOR  = 5'd5,
      OP_OR   = 5'd6,
      OP_CP   = 5'd7,
      OP_INC  = 5'd8,
      OP_DEC  = 5'd9,
      OP_DAA  = 5'd10,
      OP_CPL  = 5'd11,
      OP_SCF  = 5'd12,
      OP_CCF  = 5'd13,
      OP_SWAP = 5'd14,
      OP_BIT  = 5'd15,
      OP_SET  = 5'd16,
      OP_RES  = 5'd17
   } op_type;

   // Flag bit positions inside a flag nibble
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants
   localparam logic [7:0] DAA_LO_CORR = 8'h06;
   localparam logic [7:0] DAA_HI_CORR = 8'h60;
   localparam logic [7:0] DAA_HI_MAX  = 8'h99;
   localparam logic [3:0] DAA_LO_MAX  = 4'h9;
   localparam logic [3:0] NIBBLE_MAX  = 4'hF;

   // Input transaction
   typedef struct packed {
      logic [4:0] mode;
      logic [7:0] acc_in;
      logic [7:0] operand;
      logic [2:0] bit_index;
      logic [3:0] flags_in;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [7:0] result;
      logic       writes_back;
      logic [3:0] flags_out;
   } rsp_type;

endpackage

// File: sv/c8alu_exec.sv
`timescale 1ns / 1ps

module c8alu_exec (
   input  c8alu_pkg::req_type req,
   output c8alu_pkg::rsp_type rsp
);
   import c8alu_pkg::*;

   logic       zi, ni, hi, ci;
   logic       add_cin, sub_cin;
   logic [8:0] add_sum;
   logic [4:0] add_half;
   logic [8:0] sub_diff;
   logic [4:0] sub_half;
   logic [7:0] daa_corr;
   logic       daa_c;
   logic [7:0] daa_val;
   logic [7:0] bit_mask;
   logic [7:0] r;
   logic       z_new, n_new, h_new, c_new;
   logic       wb;
   logic       z_from_r;

   assign zi = req.flags_in[FLAG_Z];
   assign ni = req.flags_in[FLAG_N];
   assign hi = req.flags_in[FLAG_H];
   assign ci = req.flags_in[FLAG_C];

   // Adder and subtractor with carry out of bits 3 and 7
   assign add_cin  = (req.mode == OP_ADC) & ci;
   assign sub_cin  = (req.mode == OP_SBC) & ci;
   assign add_sum  = {1'b0, req.acc_in} + {1'b0, req.operand} + {8'd0, add_cin};
   assign add_half = {1'b0, req.acc_in[3:0]} + {1'b0, req.operand[3:0]} + {4'd0, add_cin};
   assign sub_diff = {1'b0, req.acc_in} - {1'b0, req.operand} - {8'd0, sub_cin};
   assign sub_half = {1'b0, req.acc_in[3:0]} - {1'b0, req.operand[3:0]} - {4'd0, sub_cin};

   // Decimal adjust correction
   always_comb begin
      daa_corr = 8'd0;
      daa_c    = ci;
      if (hi || (!ni && (req.acc_in[3:0] > DAA_LO_MAX))) begin
         daa_corr = daa_corr | DAA_LO_CORR;
      end
      if (ci || (!ni && (req.acc_in > DAA_HI_MAX))) begin
         daa_corr = daa_corr | DAA_HI_CORR;
         daa_c    = 1'b1;
      end
   end
   assign daa_val = ni ? (req.acc_in - daa_corr) : (req.acc_in + daa_corr);

   assign bit_mask = 8'd1 << req.bit_index;

   // Operation select; flags default to pass-through
   always_comb begin
      r     = req.acc_in;
      wb    = 1'b1;
      z_new = zi;
      n_new = ni;
      h_new = hi;
      c_new = ci;
      z_from_r = 1'b0;
      case (req.mode)
         OP_ADD, OP_ADC: begin
            r = add_sum[7:0];
            z_from_r = 1'b1;
            n_new = 1'b0;
            h_new = add_half[4];
            c_new = add_sum[8];
         end
         OP_SUB, OP_SBC: begin
            r = sub_diff[7:0];
            z_from_r = 1'b1;
            n_new = 1'b1;
            h_new = sub_half[4];
            c_new = sub_diff[8];
         end
         OP_CP: begin
            wb    = 1'b0;
            z_new = (sub_diff[7:0] == 8'd0);
            n_new = 1'b1;
            h_new = sub_half[4];
            c_new = sub_diff[8];
         end
         OP_AND: begin
            r = req.acc_in & req.operand;
            z_from_r = 1'b1;
            n_new = 1'b0;
            h_new = 1'b1;
            c_new = 1'b0;
         end
         OP_XOR: begin
            r = req.acc_in ^ req.operand;
            z_from_r = 1'b1;
            n_new = 1'b0;
            h_new = 1'b0;
            c_new = 1'b0;
         end
         OP_OR: begin
            r = req.acc_in | req.operand;
            z_from_r = 1'b1;
            n_new = 1'b0;
            h_new = 1'b0;
            c_new = 1'b0;
         end
         OP_INC: begin
            r = req.operand + 8'd1;
            z_from_r = 1'b1;
            n_new = 1'b0;
            h_new = (req.operand[3:0] == NIBBLE_MAX);
         end
         OP_DEC: begin
            r = req.operand - 8'd1;
            z_from_r = 1'b1;
            n_new = 1'b1;
            h_new = (req.operand[3:0] == 4'd0);
         end
         OP_DAA: begin
            r = daa_val;
            z_from_r = 1'b1;
            h_new = 1'b0;
            c_new = daa_c;
         end
         OP_CPL: begin
            r = ~req.acc_in;
            n_new = 1'b1;
            h_new = 1'b1;
         end
         OP_SCF: begin
            n_new = 1'b0;
            h_new = 1'b0;
            c_new = 1'b1;
         end
         OP_CCF: begin
            n_new = 1'b0;
            h_new = 1'b0;
            c_new = ~ci;
         end
         OP_SWAP: begin
            r = {req.operand[3:0], req.operand[7:4]};
            z_from_r = 1'b1;
            n_new = 1'b0;
            h_new = 1'b0;
            c_new = 1'b0;
         end
         OP_BIT: begin
            r     = req.operand;
            wb    = 1'b0;
            z_new = ~req.operand[req.bit_index];
            n_new = 1'b0;
            h_new = 1'b1;
         end
         OP_SET: begin
            r = req.operand | bit_mask;
         end
         OP_RES: begin
            r = req.operand & ~bit_mask;
         end
         default: begin
            // unused codes: no operation, nothing written
            wb = 1'b0;
         end
      endcase
      if (z_from_r) begin
         z_new = (r == 8'd0);
      end
   end

   assign rsp.result      = r;
   assign rsp.writes_back = wb;
   assign rsp.flags_out   = {z_new, n_new, h_new, c_new};

endmodule

// File: sv/cpu_8bit_alu_with_flags.sv
`timescale 1ns / 1ps

// 8-bit CPU ALU with Z/N/H/C flags. One transaction enters per clock while
// req_stall is low: it is captured in an input register, goes through one level
// of flat ALU logic and lands in the result register. A result is offered on
// rsp_ once it has moved from the input register into the result register, and
// with no stall the sustained rate is one transaction per cycle.
// Backpressure on rsp_stall holds the result register; the input register
// keeps accepting until both registers are full, so req_stall rises only while
// a result is held and another transaction waits behind it.
module cpu_8bit_alu_with_flags (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  c8alu_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output c8alu_pkg::rsp_type  rsp_data
);
   import c8alu_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type exec_rsp;
   logic    out_load;
   logic    in_load;

   // Pipeline advance
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= exec_rsp;
      end
   end

   c8alu_exec u_exec (
      .req (in_data_ff),
      .rsp (exec_rsp)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: sv/c8alu_checker.sv
`timescale 1ns / 1ps

module c8alu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input c8alu_pkg::rsp_type rsp_data
);
   import c8alu_pkg::*;

   // A held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // Input backpressure only when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // An accepted transaction reaches the output unless the output stalls
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted transaction did not produce a result");

endmodule

bind cpu_8bit_alu_with_flags c8alu_checker u_c8alu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
